// File: hdl/ohlc_bb_pkg.sv
// ----------------------------------------------------------------------------
// ohlc_bb_pkg
// Shared types and constants of the one-second OHLC bar builder.
// ----------------------------------------------------------------------------
package ohlc_bb_pkg;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int PRICE_W = 32;

  // Gap-fill cap: default, and the width of the fill count (62 fits in 6 bits)
  localparam int MAX_FILL_BARS_DEF = 62;
  localparam int FILL_CNT_W        = 6;

  // Depth of the job queue between front and back
  localparam int JOB_QUEUE_DEPTH = 2;

  // Input command codes
  typedef enum logic {
    CMD_TRADE   = 1'b0,
    CMD_TIMEOUT = 1'b1
  } command_t;

  // Result bar kinds
  typedef enum logic [1:0] {
    KIND_TRADE   = 2'd0,
    KIND_FILL    = 2'd1,
    KIND_TIMEOUT = 2'd2
  } bar_kind_t;

  // Work handed from front to back: an optional closed bar, then a fill run
  typedef struct packed {
    logic                    has_bar;
    bar_kind_t               bar_kind;
    logic [TIME_W-1:0]       bar_time;
    logic [PRICE_W-1:0]      open_price;
    logic [PRICE_W-1:0]      high_price;
    logic [PRICE_W-1:0]      low_price;
    logic [PRICE_W-1:0]      close_price;
    logic [FILL_CNT_W-1:0]   fill_cnt;
    logic [TIME_W-1:0]       fill_time;
    logic [PRICE_W-1:0]      fill_price;
    logic                    fill_truncated;
  } job_t;

  // One result beat
  typedef struct packed {
    bar_kind_t               bar_kind;
    logic [TIME_W-1:0]       bar_time;
    logic [PRICE_W-1:0]      open_price;
    logic [PRICE_W-1:0]      high_price;
    logic [PRICE_W-1:0]      low_price;
    logic [PRICE_W-1:0]      close_price;
    logic                    fill_truncated;
    logic                    last_of_run;
  } result_t;

endpackage

// File: hdl/ohlc_bb_front.sv
// ----------------------------------------------------------------------------
// ohlc_bb_front
// Holds the open bar, classifies each beat and issues one job per beat that
// yields results.
// ----------------------------------------------------------------------------
module ohlc_bb_front #(
  parameter int MaxFillBars = ohlc_bb_pkg::MAX_FILL_BARS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  ohlc_bb_pkg::command_t            command,
  input  logic [ohlc_bb_pkg::TIME_W-1:0]   trade_time,
  input  logic [ohlc_bb_pkg::PRICE_W-1:0]  trade_price,
  output logic                             job_push,
  output ohlc_bb_pkg::job_t                job
);

  localparam int TW = ohlc_bb_pkg::TIME_W;
  localparam int PW = ohlc_bb_pkg::PRICE_W;
  localparam int CW = ohlc_bb_pkg::FILL_CNT_W;

  logic          bar_is_open, bar_is_open_next;
  logic [TW-1:0] bar_start_time, bar_start_time_next;
  logic [PW-1:0] bar_open_price, bar_open_price_next;
  logic [PW-1:0] bar_high_price, bar_high_price_next;
  logic [PW-1:0] bar_low_price, bar_low_price_next;
  logic [PW-1:0] bar_close_price, bar_close_price_next;

  logic [TW:0]   diff;
  logic          gap_gt1;
  logic          trunc;

  // Signed gap from the bar start: negative when the top bit is set
  assign diff    = {1'b0, trade_time} - {1'b0, bar_start_time};
  assign gap_gt1 = !diff[TW] && (diff[TW-1:0] > TW'(1));
  assign trunc   = gap_gt1 && (diff[TW-1:0] > TW'(MaxFillBars + 1));

  // Classify the beat and build the job
  always_comb begin
    bar_is_open_next     = bar_is_open;
    bar_start_time_next  = bar_start_time;
    bar_open_price_next  = bar_open_price;
    bar_high_price_next  = bar_high_price;
    bar_low_price_next   = bar_low_price;
    bar_close_price_next = bar_close_price;
    job_push             = 1'b0;

    job.has_bar        = bar_is_open;
    job.bar_kind       = ohlc_bb_pkg::KIND_TRADE;
    job.bar_time       = bar_start_time;
    job.open_price     = bar_open_price;
    job.high_price     = bar_high_price;
    job.low_price      = bar_low_price;
    job.close_price    = bar_close_price;
    job.fill_cnt       = '0;
    job.fill_time      = bar_start_time + TW'(1);
    job.fill_price     = bar_close_price;
    job.fill_truncated = trunc;

    if (in_valid) begin
      unique case (command)
        ohlc_bb_pkg::CMD_TIMEOUT: begin
          // Close the open bar as history-only
          job.bar_kind     = ohlc_bb_pkg::KIND_TIMEOUT;
          job_push         = bar_is_open;
          bar_is_open_next = 1'b0;
        end
        ohlc_bb_pkg::CMD_TRADE: begin
          if (bar_is_open && !gap_gt1) begin
            // Update the open bar
            bar_close_price_next = trade_price;
            if (trade_price < bar_low_price) begin
              bar_low_price_next = trade_price;
            end
            if (trade_price > bar_high_price) begin
              bar_high_price_next = trade_price;
            end
          end else begin
            // Emit the open bar and any gap fill, then open a new bar
            if (gap_gt1) begin
              job.fill_cnt = trunc ? CW'(MaxFillBars) : (diff[CW-1:0] - CW'(1));
            end
            job_push             = bar_is_open || gap_gt1;
            bar_is_open_next     = 1'b1;
            bar_start_time_next  = trade_time;
            bar_open_price_next  = trade_price;
            bar_high_price_next  = trade_price;
            bar_low_price_next   = trade_price;
            bar_close_price_next = trade_price;
          end
        end
        default: begin
          job_push = 1'b0;
        end
      endcase
    end
  end

  // Hold the bar state
  always_ff @(posedge clk) begin
    if (rst) begin
      bar_is_open     <= 1'b0;
      bar_start_time  <= '0;
      bar_open_price  <= '0;
      bar_high_price  <= '0;
      bar_low_price   <= '0;
      bar_close_price <= '0;
    end else begin
      bar_is_open     <= bar_is_open_next;
      bar_start_time  <= bar_start_time_next;
      bar_open_price  <= bar_open_price_next;
      bar_high_price  <= bar_high_price_next;
      bar_low_price   <= bar_low_price_next;
      bar_close_price <= bar_close_price_next;
    end
  end

  // A job never asks for more flat bars than the cap
  assert property (@(posedge clk) disable iff (rst)
    job_push |-> (job.fill_cnt <= CW'(MaxFillBars)))
    else $error("fill count above cap");

  // Every issued job yields at least one result
  assert property (@(posedge clk) disable iff (rst)
    job_push |-> (job.has_bar || (job.fill_cnt != '0)))
    else $error("empty job issued");

endmodule

// File: hdl/ohlc_bb_queue.sv
// ----------------------------------------------------------------------------
// ohlc_bb_queue
// Short first-in first-out queue of jobs between front and back.
// ----------------------------------------------------------------------------
module ohlc_bb_queue #(
  parameter int Depth = ohlc_bb_pkg::JOB_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  ohlc_bb_pkg::job_t wr_job,
  output logic              q_full,
  input  logic              rd_en,
  output logic              rd_valid,
  output ohlc_bb_pkg::job_t rd_job
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ohlc_bb_pkg::job_t slots [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign q_full   = (count == CntW'(Depth));
  assign rd_valid = (count != '0);
  assign rd_job   = slots[rd_ptr];

  // Store a job
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Advance pointers and the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

  // Never write a full queue nor read an empty one
  assert property (@(posedge clk) disable iff (rst)
    !(wr_en && q_full) && !(rd_en && !rd_valid))
    else $error("job queue overrun or underrun");

endmodule

// File: hdl/ohlc_bb_back.sv
// ----------------------------------------------------------------------------
// ohlc_bb_back
// Expands jobs into registered result beats, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ohlc_bb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  ohlc_bb_pkg::job_t    q_job,
  output logic                 q_pop,
  output logic                 out_valid,
  output ohlc_bb_pkg::result_t out_res,
  input  logic                 out_pop
);

  localparam int TW = ohlc_bb_pkg::TIME_W;
  localparam int CW = ohlc_bb_pkg::FILL_CNT_W;

  ohlc_bb_pkg::job_t    cur;
  logic                 active;
  logic                 bar_pending;
  logic                 advance;
  logic                 emit_last;
  ohlc_bb_pkg::result_t res;

  assign advance   = active && (!out_valid || out_pop);
  assign emit_last = bar_pending ? (cur.fill_cnt == '0) : (cur.fill_cnt == CW'(1));
  assign q_pop     = q_valid && (!active || (advance && emit_last));

  // Form the next result beat
  always_comb begin
    if (bar_pending) begin
      res.bar_kind       = cur.bar_kind;
      res.bar_time       = cur.bar_time;
      res.open_price     = cur.open_price;
      res.high_price     = cur.high_price;
      res.low_price      = cur.low_price;
      res.close_price    = cur.close_price;
      res.fill_truncated = 1'b0;
    end else begin
      res.bar_kind       = ohlc_bb_pkg::KIND_FILL;
      res.bar_time       = cur.fill_time;
      res.open_price     = cur.fill_price;
      res.high_price     = cur.fill_price;
      res.low_price      = cur.fill_price;
      res.close_price    = cur.fill_price;
      res.fill_truncated = cur.fill_truncated;
    end
    res.last_of_run = emit_last;
  end

  // Control: job activity, pending bar, output occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      bar_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        bar_pending <= 1'b0;
        if (emit_last) begin
          active <= 1'b0;
        end
      end
      if (q_pop) begin
        active      <= 1'b1;
        bar_pending <= q_job.has_bar;
      end
    end
  end

  // Payload: current job and output beat
  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
      if (!bar_pending) begin
        cur.fill_cnt  <= cur.fill_cnt - CW'(1);
        cur.fill_time <= cur.fill_time + TW'(1);
      end
    end
    if (q_pop) begin
      cur <= q_job;
    end
  end

  // An active job always has a beat left to emit
  assert property (@(posedge clk) disable iff (rst)
    active |-> (bar_pending || (cur.fill_cnt != '0)))
    else $error("active job with nothing left");

  // Truncation is only flagged on flat gap-fill bars
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.fill_truncated) |-> (out_res.bar_kind == ohlc_bb_pkg::KIND_FILL))
    else $error("truncation flag on non-fill bar");

endmodule

// File: hdl/ohlc_bar_builder_gap_fill_top.sv
// ----------------------------------------------------------------------------
// ohlc_bar_builder_gap_fill_top
// One-second OHLC bar builder with capped flat gap-fill bars.
// ----------------------------------------------------------------------------
// Path: a beat's first result reaches the result ports through the job queue,
//   the back's job register and the output register.
// Throughput: one input beat per cycle while the job queue has room; the back
//   emits one result per cycle while results are popped, so a job of up to
//   MaxFillBars + 1 results holds it while the 2-entry queue fills to full.
// Reset: synchronous rst clears the bar state, the job queue and the out reg.
module ohlc_bar_builder_gap_fill_top #(
  parameter int MaxFillBars = ohlc_bb_pkg::MAX_FILL_BARS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             command,
  input  logic [ohlc_bb_pkg::TIME_W-1:0]   trade_time,
  input  logic [ohlc_bb_pkg::PRICE_W-1:0]  trade_price,
  output logic                             empty,
  input  logic                             pop,
  output logic [1:0]                       bar_kind,
  output logic [ohlc_bb_pkg::TIME_W-1:0]   bar_time,
  output logic [ohlc_bb_pkg::PRICE_W-1:0]  open_price,
  output logic [ohlc_bb_pkg::PRICE_W-1:0]  high_price,
  output logic [ohlc_bb_pkg::PRICE_W-1:0]  low_price,
  output logic [ohlc_bb_pkg::PRICE_W-1:0]  close_price,
  output logic                             fill_truncated,
  output logic                             last_of_run
);

  logic                 in_valid;
  logic                 job_push;
  ohlc_bb_pkg::job_t    job;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_valid;
  ohlc_bb_pkg::job_t    q_job;
  logic                 out_valid;
  ohlc_bb_pkg::result_t out_res;

  // Accept a beat only while the job queue has room
  assign full     = q_full;
  assign in_valid = push && !q_full;

  ohlc_bb_front #(
    .MaxFillBars (MaxFillBars)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .command     (ohlc_bb_pkg::command_t'(command)),
    .trade_time  (trade_time),
    .trade_price (trade_price),
    .job_push    (job_push),
    .job         (job)
  );

  ohlc_bb_queue #(
    .Depth (ohlc_bb_pkg::JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_job   (job),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  ohlc_bb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_pop   (pop)
  );

  // Drive the result ports from the output register
  assign empty          = !out_valid;
  assign bar_kind       = out_res.bar_kind;
  assign bar_time       = out_res.bar_time;
  assign open_price     = out_res.open_price;
  assign high_price     = out_res.high_price;
  assign low_price      = out_res.low_price;
  assign close_price    = out_res.close_price;
  assign fill_truncated = out_res.fill_truncated;
  assign last_of_run    = out_res.last_of_run;

endmodule

// File: tb/tb_ohlc_bar_builder_gap_fill_top.sv
// ----------------------------------------------------------------------------
// tb_ohlc_bar_builder_gap_fill_top
// Self-checking bench for the one-second OHLC bar builder with gap fill.
// A directed table covers reset behaviour, price and time extremes, the fill
// cap edges and the timeout cases. A random trade feed follows, mostly
// well-formed bars with random prices and occasional jumps. Every result beat
// is checked against a bar predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_ohlc_bar_builder_gap_fill_top;

  localparam int FILL_CAP       = ohlc_bb_pkg::MAX_FILL_BARS_DEF;
  localparam int RAND_ITEMS     = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 12;
  localparam int MAX_PRINTS     = 200;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // One row of the directed table; typed rows carry their bar count and first bar
  typedef struct {
    ohlc_bb_pkg::command_t cmd;
    logic [31:0]           t;
    logic [31:0]           p;
    bit                    typed;
    int                    n_bars;
    ohlc_bb_pkg::result_t  first_bar;
  } stim_row_t;

  logic                             clk         = 1'b0;
  logic                             rst         = 1'b1;
  logic                             push        = 1'b0;
  logic                             command     = ohlc_bb_pkg::CMD_TRADE;
  logic [ohlc_bb_pkg::TIME_W-1:0]   trade_time  = '0;
  logic [ohlc_bb_pkg::PRICE_W-1:0]  trade_price = '0;
  logic                             pop         = 1'b0;
  logic                             full;
  logic                             empty;
  logic [1:0]                       bar_kind;
  logic [ohlc_bb_pkg::TIME_W-1:0]   bar_time;
  logic [ohlc_bb_pkg::PRICE_W-1:0]  open_price;
  logic [ohlc_bb_pkg::PRICE_W-1:0]  high_price;
  logic [ohlc_bb_pkg::PRICE_W-1:0]  low_price;
  logic [ohlc_bb_pkg::PRICE_W-1:0]  close_price;
  logic                             fill_truncated;
  logic                             last_of_run;

  // Expected bars in output order, and the bars caused by the latest beat
  ohlc_bb_pkg::result_t pending_bars[$];
  ohlc_bb_pkg::result_t fresh_bars[$];

  // Predictor copy of the bar state
  bit          open_flag = 1'b0;
  logic [31:0] cur_start = '0;
  logic [31:0] cur_open  = '0;
  logic [31:0] cur_high  = '0;
  logic [31:0] cur_low   = '0;
  logic [31:0] cur_close = '0;

  int err_cnt        = 0;
  bit random_started = 1'b0;

  ohlc_bar_builder_gap_fill_top #(
    .MaxFillBars(FILL_CAP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .command(command),
    .trade_time(trade_time),
    .trade_price(trade_price),
    .empty(empty),
    .pop(pop),
    .bar_kind(bar_kind),
    .bar_time(bar_time),
    .open_price(open_price),
    .high_price(high_price),
    .low_price(low_price),
    .close_price(close_price),
    .fill_truncated(fill_truncated),
    .last_of_run(last_of_run)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic ohlc_bb_pkg::result_t bar_beat(ohlc_bb_pkg::bar_kind_t k,
                                                    logic [31:0] tm, logic [31:0] o,
                                                    logic [31:0] h, logic [31:0] l,
                                                    logic [31:0] c,
                                                    logic trunc, logic last);
    ohlc_bb_pkg::result_t r;
    r.bar_kind       = k;
    r.bar_time       = tm;
    r.open_price     = o;
    r.high_price     = h;
    r.low_price      = l;
    r.close_price    = c;
    r.fill_truncated = trunc;
    r.last_of_run    = last;
    return r;
  endfunction

  function automatic stim_row_t stim_row(ohlc_bb_pkg::command_t cmd, logic [31:0] t,
                                         logic [31:0] p,
                                         bit typed = 1'b0, int n_bars = 0,
                                         ohlc_bb_pkg::result_t first_bar = '0);
    stim_row_t s;
    s.cmd       = cmd;
    s.t         = t;
    s.p         = p;
    s.typed     = typed;
    s.n_bars    = n_bars;
    s.first_bar = first_bar;
    return s;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (err_cnt < MAX_PRINTS)
      $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    err_cnt++;
  endtask

  // Work out the bars one accepted beat emits and advance the bar state
  task automatic predict_bars(input ohlc_bb_pkg::command_t cmd, input logic [31:0] t,
                              input logic [31:0] p);
    longint gap;
    longint want;
    int     cnt;
    int     i;
    logic   trunc;
    fresh_bars.delete();
    gap = longint'({32'd0, t}) - longint'({32'd0, cur_start});
    if (cmd == ohlc_bb_pkg::CMD_TIMEOUT) begin
      // close an open bar as history-only, ignore otherwise
      if (open_flag) begin
        fresh_bars.push_back(bar_beat(ohlc_bb_pkg::KIND_TIMEOUT, cur_start, cur_open,
                                      cur_high, cur_low, cur_close, 1'b0, 1'b0));
        open_flag = 1'b0;
      end
    end else if (open_flag && gap <= 1) begin
      // trade inside the bar: update close and extremes
      cur_close = p;
      if (p < cur_low) cur_low = p;
      if (p > cur_high) cur_high = p;
    end else begin
      // emit the open bar, fill the skipped seconds, then open a new bar
      if (open_flag) begin
        fresh_bars.push_back(bar_beat(ohlc_bb_pkg::KIND_TRADE, cur_start, cur_open,
                                      cur_high, cur_low, cur_close, 1'b0, 1'b0));
        open_flag = 1'b0;
      end
      if (gap > 1) begin
        want  = gap - 1;
        trunc = (want > FILL_CAP);
        cnt   = trunc ? FILL_CAP : int'(want);
        for (i = 1; i <= cnt; i++) begin
          fresh_bars.push_back(bar_beat(ohlc_bb_pkg::KIND_FILL, cur_start + 32'(i),
                                        cur_close, cur_close, cur_close, cur_close,
                                        trunc, 1'b0));
        end
      end
      cur_start = t;
      cur_open  = p;
      cur_high  = p;
      cur_low   = p;
      cur_close = p;
      open_flag = 1'b1;
    end
    if (fresh_bars.size() > 0) fresh_bars[fresh_bars.size() - 1].last_of_run = 1'b1;
  endtask

  // Offer one beat, hold it until accepted, then record what it must produce.
  // push stays high afterwards so that back-to-back beats need no re-raise.
  task automatic offer_item(input ohlc_bb_pkg::command_t cmd, input logic [31:0] t,
                            input logic [31:0] p, input bit typed, input int n_bars,
                            input ohlc_bb_pkg::result_t first_bar);
    push        <= 1'b1;
    command     <= cmd;
    trade_time  <= t;
    trade_price <= p;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    predict_bars(cmd, t, p);
    if (typed) begin
      if (fresh_bars.size() != n_bars)
        report_mismatch("directed bar count", 32'(n_bars), 32'(fresh_bars.size()));
      else if (n_bars > 0)
        fresh_bars[0] = first_bar;
    end
    foreach (fresh_bars[i]) pending_bars.push_back(fresh_bars[i]);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      push <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold the feed until every expected bar has come out
  task automatic drain_bars();
    push <= 1'b0;
    @(posedge clk);
    while (pending_bars.size() != 0) @(posedge clk);
  endtask

  // Sender: reset, directed table, random feed, end of run
  initial begin
    stim_row_t             rows[$];
    int                    k;
    int                    r;
    ohlc_bb_pkg::command_t cmd;
    logic [31:0]           t;
    logic [31:0]           p;

    // timeout straight after reset: no bar open, nothing out
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TIMEOUT, 32'd0, 32'd0, 1'b1, 0));
    // first trade: truncated run of zero-price fill bars from second one
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd1000, 32'd100, 1'b1, FILL_CAP,
                            bar_beat(ohlc_bb_pkg::KIND_FILL, 32'd1, '0, '0, '0, '0,
                                     1'b1, 1'b0)));
    // updates at the price extremes, one second on and one second early
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd1000, ALL_ONES));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd1001, 32'd0));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd999, 32'd500));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TIMEOUT, 32'd0, 32'd0, 1'b1, 1,
                            bar_beat(ohlc_bb_pkg::KIND_TIMEOUT, 32'd1000, 32'd100,
                                     ALL_ONES, 32'd0, 32'd500, 1'b0, 1'b1)));
    // second timeout with the bar already closed
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TIMEOUT, ALL_ONES, ALL_ONES, 1'b1, 0));
    // short fills with no bar open, then a trade-closed bar with one fill
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd1003, 32'd7));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd1005, 32'd8));
    // gap just at the cap, then just over it
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd1068, 32'd9));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd1132, 32'd10));
    // far-earlier trade still updates the open bar
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd0, 32'd1));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TIMEOUT, 32'd0, 32'd0, 1'b1, 1,
                            bar_beat(ohlc_bb_pkg::KIND_TIMEOUT, 32'd1132, 32'd10,
                                     32'd10, 32'd1, 32'd1, 1'b0, 1'b1)));
    // earlier trade with no bar open: no fill, opens a bar
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd1131, 32'd3, 1'b1, 0));
    // jump to the last second of the time range
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, ALL_ONES, ALL_ONES));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, ALL_ONES, 32'd0));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd0, 32'd5));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TIMEOUT, 32'd0, 32'd0, 1'b1, 1,
                            bar_beat(ohlc_bb_pkg::KIND_TIMEOUT, ALL_ONES, ALL_ONES,
                                     ALL_ONES, 32'd0, 32'd5, 1'b0, 1'b1)));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd0, 32'd6, 1'b1, 0));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd2, 32'd7));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd3, 32'd8));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TIMEOUT, 32'd0, 32'd0));
    // exactly one second after a closed bar: no fill
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'd3, 32'd9, 1'b1, 0));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TIMEOUT, 32'd0, 32'd0));
    rows.push_back(stim_row(ohlc_bb_pkg::CMD_TRADE, 32'hAAAA_AAAA, 32'h5555_5555));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // walk the directed table
    foreach (rows[i]) begin
      offer_item(rows[i].cmd, rows[i].t, rows[i].p, rows[i].typed, rows[i].n_bars,
                 rows[i].first_bar);
      idle_sender(gap_len());
    end
    drain_bars();
    random_started = 1'b1;

    // random feed: mostly trades near the open bar, some jumps and timeouts
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k == RAND_ITEMS / 2) drain_bars();
      if ($urandom_range(0, 9) == 0) begin
        cmd = ohlc_bb_pkg::CMD_TIMEOUT;
        t   = $urandom;
        p   = $urandom;
      end else begin
        cmd = ohlc_bb_pkg::CMD_TRADE;
        r   = $urandom_range(0, 99);
        if (r < 70)      t = cur_start + 32'($urandom_range(0, 2)) - 32'd1;
        else if (r < 85) t = cur_start + 32'($urandom_range(2, 8));
        else if (r < 92) t = cur_start + 32'($urandom_range(FILL_CAP - 2, FILL_CAP + 4));
        else if (r < 96) t = cur_start + 32'($urandom_range(FILL_CAP + 5, 5000));
        else             t = $urandom;
        if ($urandom_range(0, 1) == 0) p = cur_close + 32'($urandom_range(0, 200)) - 32'd100;
        else                           p = $urandom;
      end
      offer_item(cmd, t, p, 1'b0, 0, '0);
      // bursts with no idling on part of the feed
      if ((k % 50) >= 15) idle_sender(gap_len());
    end

    drain_bars();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: check each popped beat, then choose pop for the next cycle
  initial begin
    ohlc_bb_pkg::result_t want;
    int                   idle_left;
    int                   cyc;
    int                   mode;
    bit                   long_done;
    idle_left = 0;
    cyc       = 0;
    long_done = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (pop && empty === 1'b0) begin
        if (pending_bars.size() == 0) begin
          report_mismatch("unexpected beat, bar_time", '0, bar_time);
        end else begin
          want = pending_bars.pop_front();
          if (bar_kind !== want.bar_kind)
            report_mismatch("bar_kind", 32'(want.bar_kind), 32'(bar_kind));
          if (bar_time !== want.bar_time)
            report_mismatch("bar_time", want.bar_time, bar_time);
          if (open_price !== want.open_price)
            report_mismatch("open_price", want.open_price, open_price);
          if (high_price !== want.high_price)
            report_mismatch("high_price", want.high_price, high_price);
          if (low_price !== want.low_price)
            report_mismatch("low_price", want.low_price, low_price);
          if (close_price !== want.close_price)
            report_mismatch("close_price", want.close_price, close_price);
          if (fill_truncated !== want.fill_truncated)
            report_mismatch("fill_truncated", 32'(want.fill_truncated), 32'(fill_truncated));
          if (last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 32'(want.last_of_run), 32'(last_of_run));
        end
      end
      // hold off once for a long stretch so the block backs up and stalls its input
      if (random_started && !long_done) begin
        idle_left = LONG_HOLD;
        long_done = 1'b1;
      end
      // phases of no stalls, light stalls and heavy stalls
      mode = (cyc / 300) % 3;
      if (idle_left > 0) begin
        pop <= 1'b0;
        idle_left--;
      end else begin
        pop <= 1'b1;
        if (mode == 1 && $urandom_range(0, 3) == 0) idle_left = gap_len();
        else if (mode == 2 && $urandom_range(0, 1) == 0) idle_left = gap_len() + 1;
      end
    end
  end

  // Watchdog: end the run after too long with no beat accepted on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && full === 1'b0) || (pop && empty === 1'b0)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
